// ----- hdl/iras_pkg.sv -----
// Package for the interval room allocator: field widths, item structs,
// cell control struct and the sequencer state type.
// No dependencies.
package iras_pkg;

    localparam int DAY_W      = 30;
    localparam int ID_W       = 16;
    localparam int ROOM_OUT_W = 9;
    localparam int MAX_ROOMS_DEFAULT = 256;

    typedef struct packed {
        logic [DAY_W-1:0] arrival_day;
        logic [DAY_W-1:0] departure_day;
        logic [ID_W-1:0]  customer_id;
        logic             new_batch;
    } req_t;

    typedef struct packed {
        logic [ID_W-1:0]       customer_id_out;
        logic [ROOM_OUT_W-1:0] assigned_room;
        logic [ROOM_OUT_W-1:0] rooms_opened;
        logic                  overflow;
    } rsp_t;

    // What the row of cells does on the update cycle
    typedef enum logic [1:0] {
        OP_HOLD,
        OP_REPLACE,  // drop the head entry, insert the key
        OP_INSERT    // insert the key, tail grows by one
    } cell_op_t;

    typedef struct packed {
        cell_op_t         op;
        logic [DAY_W-1:0] key_dep;
    } cell_ctrl_t;

    typedef enum logic {
        ST_IDLE,
        ST_BUSY
    } seq_state_t;

endpackage

// ----- hdl/interval_room_allocator_unit.sv -----
// Top level of the interval room allocator: request register, sequencer,
// row of iras_cell slots and result register. Depends on iras_pkg, iras_cell.
//
// Usage:
//   Requests (req_item: arrival, departure, customer id, new_batch) enter on
//   req_valid/req_stall, in nondecreasing arrival order. Each request yields
//   exactly one item on rsp_valid/rsp_stall: the room given (0 on overflow),
//   the rooms opened so far in the batch and the overflow flag.
//   Busy rooms live in a row of MAX_ROOMS cells kept sorted by
//   (departure, room); cell 0 holds the earliest departure when the list is not empty.
//   Flow: an accepted request is loaded into the input register; the row of
//   cells, the room count and the result register are then updated together.
//   A new request is not taken before the last one is finished: the input
//   register is held while the row of cells updates, and req_stall is high.
//   Receiver stall: the result register holds its item; a finished request
//   waits in the input register until the result slot frees up, and
//   req_stall stays high meanwhile.
//   Reset: clears the room count (empty batch) and both handshake stages.
//   Cell contents are not cleared; only slots below the count are looked at.
//   new_batch empties the room list before the request is handled.
module interval_room_allocator_unit #(
    parameter int MAX_ROOMS = iras_pkg::MAX_ROOMS_DEFAULT
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           req_valid,
    output logic           req_stall,
    input  iras_pkg::req_t req_item,
    output logic           rsp_valid,
    input  logic           rsp_stall,
    output iras_pkg::rsp_t rsp_item
);
    import iras_pkg::*;

    localparam int CNT_W = $clog2(MAX_ROOMS + 1);

    seq_state_t       state_reg, state_next;
    req_t             req_reg;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             rsp_valid_reg, rsp_valid_next;
    rsp_t             rsp_reg;

    logic             req_take;
    logic             commit;
    logic [CNT_W-1:0] cnt_eff;
    logic [CNT_W-1:0] cnt_inc;
    logic             reuse;
    logic             open_room;
    logic [CNT_W-1:0] key_room;
    cell_ctrl_t       ctrl;
    rsp_t             rsp_new;

    logic [DAY_W-1:0] dep_w  [MAX_ROOMS];
    logic [CNT_W-1:0] room_w [MAX_ROOMS];
    logic             lt_w   [MAX_ROOMS];

    // ---------------- handshake and sequencer ----------------
    assign req_stall = (state_reg != ST_IDLE);
    assign req_take  = req_valid && !req_stall;
    assign rsp_valid = rsp_valid_reg;
    assign rsp_item  = rsp_reg;

    always_comb
    begin
        state_next = state_reg;
        commit     = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                if (req_valid)
                    state_next = ST_BUSY;
            end
            ST_BUSY:
            begin
                // finish only when the result slot is free or emptying
                if (!rsp_valid_reg || !rsp_stall)
                begin
                    commit     = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        rsp_valid_next = rsp_valid_reg && rsp_stall;
        if (commit)
            rsp_valid_next = 1'b1;
    end

    // ---------------- decision on the head cell ----------------
    // new_batch empties the list before this request is looked at
    assign cnt_eff   = req_reg.new_batch ? '0 : count_reg;
    assign cnt_inc   = cnt_eff + CNT_W'(1);
    assign reuse     = (cnt_eff != '0) && (dep_w[0] < req_reg.arrival_day);
    assign open_room = !reuse && (cnt_eff < CNT_W'(MAX_ROOMS));
    assign key_room  = reuse ? room_w[0] : cnt_inc;

    always_comb
    begin
        ctrl.key_dep = req_reg.departure_day;
        ctrl.op      = OP_HOLD;
        if (commit && reuse)
            ctrl.op = OP_REPLACE;
        else if (commit && open_room)
            ctrl.op = OP_INSERT;
    end

    always_comb
    begin
        count_next = count_reg;
        if (commit)
            count_next = open_room ? cnt_inc : cnt_eff;
    end

    always_comb
    begin
        rsp_new.customer_id_out = req_reg.customer_id;
        rsp_new.assigned_room   = (reuse || open_room) ?
                                  ROOM_OUT_W'(key_room) : '0;
        rsp_new.rooms_opened    = open_room ? ROOM_OUT_W'(cnt_inc) :
                                              ROOM_OUT_W'(cnt_eff);
        rsp_new.overflow        = !reuse && !open_room;
    end

    // ---------------- row of cells ----------------
    for (genvar i = 0; i < MAX_ROOMS; i++)
    begin : g_cell
        logic             left_lt;
        logic [DAY_W-1:0] left_dep;
        logic [CNT_W-1:0] left_room;
        logic             right_lt;
        logic [DAY_W-1:0] right_dep;
        logic [CNT_W-1:0] right_room;

        if (i == 0)
        begin : g_first
            // key always lands in slot 0 when nothing smaller is there
            assign left_lt   = 1'b1;
            assign left_dep  = '0;
            assign left_room = '0;
        end
        else
        begin : g_mid_l
            assign left_lt   = lt_w[i-1];
            assign left_dep  = dep_w[i-1];
            assign left_room = room_w[i-1];
        end

        if (i == MAX_ROOMS - 1)
        begin : g_last
            assign right_lt   = 1'b0;
            assign right_dep  = '0;
            assign right_room = '0;
        end
        else
        begin : g_mid_r
            assign right_lt   = lt_w[i+1];
            assign right_dep  = dep_w[i+1];
            assign right_room = room_w[i+1];
        end

        iras_cell #(
            .IDX   (i),
            .CNT_W (CNT_W)
        ) u_cell (
            .clk        (clk),
            .ctrl       (ctrl),
            .key_room   (key_room),
            .cnt        (cnt_eff),
            .left_lt    (left_lt),
            .left_dep   (left_dep),
            .left_room  (left_room),
            .right_lt   (right_lt),
            .right_dep  (right_dep),
            .right_room (right_room),
            .own_lt     (lt_w[i]),
            .dep        (dep_w[i]),
            .room       (room_w[i])
        );
    end

    // ---------------- registers ----------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            count_reg     <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (req_take)
            req_reg <= req_item;
        if (commit)
            rsp_reg <= rsp_new;
    end

endmodule

// ----- hdl/iras_cell.sv -----
// One slot of the sorted busy-room list: holds (departure, room) and
// shifts toward its neighbors on insert or replace. Depends on iras_pkg.
module iras_cell #(
    parameter int IDX   = 0,
    parameter int CNT_W = 9
) (
    input  logic                         clk,
    input  iras_pkg::cell_ctrl_t         ctrl,
    input  logic [CNT_W-1:0]             key_room,
    input  logic [CNT_W-1:0]             cnt,
    input  logic                         left_lt,
    input  logic [iras_pkg::DAY_W-1:0]   left_dep,
    input  logic [CNT_W-1:0]             left_room,
    input  logic                         right_lt,
    input  logic [iras_pkg::DAY_W-1:0]   right_dep,
    input  logic [CNT_W-1:0]             right_room,
    output logic                         own_lt,
    output logic [iras_pkg::DAY_W-1:0]   dep,
    output logic [CNT_W-1:0]             room
);
    import iras_pkg::*;

    logic [DAY_W-1:0] dep_reg,  dep_next;
    logic [CNT_W-1:0] room_reg, room_next;
    logic             own_valid;

    // slots at or past the occupancy count act as +infinity
    assign own_valid = CNT_W'(IDX) < cnt;
    assign own_lt    = own_valid &&
                       ({dep_reg, room_reg} < {ctrl.key_dep, key_room});
    assign dep  = dep_reg;
    assign room = room_reg;

    always_comb
    begin
        dep_next  = dep_reg;
        room_next = room_reg;
        case (ctrl.op)
            OP_REPLACE:
            begin
                if (right_lt)
                begin
                    dep_next  = right_dep;
                    room_next = right_room;
                end
                else if ((IDX == 0) || own_lt)
                begin
                    dep_next  = ctrl.key_dep;
                    room_next = key_room;
                end
            end
            OP_INSERT:
            begin
                if (!own_lt)
                begin
                    if (left_lt)
                    begin
                        dep_next  = ctrl.key_dep;
                        room_next = key_room;
                    end
                    else
                    begin
                        dep_next  = left_dep;
                        room_next = left_room;
                    end
                end
            end
            default:
            begin
                dep_next  = dep_reg;
                room_next = room_reg;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        dep_reg  <= dep_next;
        room_reg <= room_next;
    end

endmodule
